>>> design/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg: shared types and helpers for the integer literal parser
// Character codes, scan phases, number bases and the digit decoder.
// ----------------------------------------------------------------------------
package ilp_pkg;

   localparam int ValueWidth = 64;
   localparam int CharWidth  = 8;
   // Product width: value times sixteen plus one digit
   localparam int WideWidth  = ValueWidth + 4;

   localparam logic [CharWidth-1:0] CharMinus = 8'h2d;  // '-'
   localparam logic [CharWidth-1:0] CharZero  = 8'h30;  // '0'
   localparam logic [CharWidth-1:0] CharNine  = 8'h39;  // '9'
   localparam logic [CharWidth-1:0] CharLowA  = 8'h61;  // 'a'
   localparam logic [CharWidth-1:0] CharLowB  = 8'h62;  // 'b'
   localparam logic [CharWidth-1:0] CharLowF  = 8'h66;  // 'f'
   localparam logic [CharWidth-1:0] CharLowX  = 8'h78;  // 'x'
   localparam logic [CharWidth-1:0] CharUpA   = 8'h41;  // 'A'
   localparam logic [CharWidth-1:0] CharUpF   = 8'h46;  // 'F'

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_MINUS  = 2'd1,
      PH_ZERO   = 2'd2,
      PH_DIGITS = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_BIN = 2'd1,
      BASE_OCT = 2'd2,
      BASE_HEX = 2'd3
   } base_type;

   // Finished literal handed from the scanner to the output stage
   typedef struct packed {
      logic                  ok;
      logic                  negative;
      logic [ValueWidth-1:0] magnitude;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   // Decode a character as a digit of the given base
   function automatic digit_type decode_digit(logic [CharWidth-1:0] c, base_type base);
      digit_type d;
      logic [CharWidth-1:0] off;
      d   = '0;
      off = '0;
      if (c >= CharZero && c <= CharNine) begin
         off = c - CharZero;
         d.valid = 1'b1;
         d.value = off[3:0];
      end else if (c >= CharLowA && c <= CharLowF) begin
         off = c - CharLowA + 8'd10;
         d.valid = 1'b1;
         d.value = off[3:0];
      end else if (c >= CharUpA && c <= CharUpF) begin
         off = c - CharUpA + 8'd10;
         d.valid = 1'b1;
         d.value = off[3:0];
      end
      unique case (base)
         BASE_BIN: if (d.value > 4'd1) d.valid = 1'b0;
         BASE_OCT: if (d.value > 4'd7) d.valid = 1'b0;
         BASE_DEC: if (d.value > 4'd9) d.valid = 1'b0;
         BASE_HEX: ;
         default:  d.valid = 1'b0;
      endcase
      return d;
   endfunction

endpackage

>>> design/ilp_scan.sv
// ----------------------------------------------------------------------------
// ilp_scan: literal scanner
// Holds the per-literal state and folds one character per taken cycle into the
// accumulator; shows the finished literal while the last item is taken.
// ----------------------------------------------------------------------------
module ilp_scan
   import ilp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [CharWidth-1:0] char_code,
   input  logic                 char_present,
   input  logic                 last_char,
   output result_type           result
);

   phase_type             phase_ff, phase_in;
   base_type              base_ff, base_in;
   logic                  negative_ff, negative_in;
   logic [ValueWidth-1:0] acc_ff, acc_in;
   logic                  seen_ff, seen_in;
   logic                  overflow_ff, overflow_in;
   logic                  stopped_ff, stopped_in;

   digit_type             digit;
   logic [WideWidth-1:0]  acc_wide;
   logic [WideWidth-1:0]  scaled;
   logic [WideWidth-1:0]  product;
   logic                  feed;
   logic                  is_prefix;

   assign acc_wide = {4'd0, acc_ff};
   assign digit    = decode_digit(char_code, base_ff);

   always_comb begin
      unique case (base_ff)
         BASE_BIN: scaled = acc_wide << 1;
         BASE_OCT: scaled = acc_wide << 3;
         BASE_HEX: scaled = acc_wide << 4;
         BASE_DEC: scaled = (acc_wide << 3) + (acc_wide << 1);
         default:  scaled = '0;
      endcase
   end

   assign product   = scaled + {{(WideWidth-4){1'b0}}, digit.value};
   assign is_prefix = (char_code == CharLowB) || (char_code == CharLowX);

   // Next state: phase decisions first, digit accumulation after
   always_comb begin
      phase_in    = phase_ff;
      base_in     = base_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      overflow_in = overflow_ff;
      stopped_in  = stopped_ff;
      feed        = 1'b0;
      if (char_present) begin
         unique case (phase_ff)
            PH_START, PH_MINUS: begin
               if (phase_ff == PH_START && char_code == CharMinus) begin
                  negative_in = 1'b1;
                  phase_in    = PH_MINUS;
               end else if (char_code == CharZero) begin
                  base_in  = BASE_OCT;
                  acc_in   = '0;
                  seen_in  = 1'b1;
                  phase_in = PH_ZERO;
               end else begin
                  phase_in = PH_DIGITS;
                  feed     = 1'b1;
               end
            end
            PH_ZERO: begin
               phase_in = PH_DIGITS;
               if (is_prefix) begin
                  base_in = (char_code == CharLowB) ? BASE_BIN : BASE_HEX;
                  acc_in  = '0;
                  seen_in = 1'b0;
               end else begin
                  feed = 1'b1;
               end
            end
            PH_DIGITS: feed = 1'b1;
            default:   feed = 1'b0;
         endcase
      end
      if (feed && !stopped_ff) begin
         if (!digit.valid) begin
            stopped_in = 1'b1;
         end else begin
            overflow_in = overflow_ff | (product[WideWidth-1:ValueWidth] != '0);
            acc_in      = product[ValueWidth-1:0];
            seen_in     = 1'b1;
         end
      end
   end

   always_comb begin
      result.ok        = seen_in && !overflow_in;
      result.negative  = negative_in;
      result.magnitude = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last_char)) begin
         phase_ff    <= PH_START;
         base_ff     <= BASE_DEC;
         negative_ff <= 1'b0;
         acc_ff      <= '0;
         seen_ff     <= 1'b0;
         overflow_ff <= 1'b0;
         stopped_ff  <= 1'b0;
      end else if (take) begin
         phase_ff    <= phase_in;
         base_ff     <= base_in;
         negative_ff <= negative_in;
         acc_ff      <= acc_in;
         seen_ff     <= seen_in;
         overflow_ff <= overflow_in;
         stopped_ff  <= stopped_in;
      end
   end

endmodule

>>> design/integer_literal_parser.sv
// A last item passes the input register, the scan stage and the output register
// before rsp_tvalid rises, and waits longer while the result side stalls.
// Throughput: one item per cycle unless a last item waits for room; the scanner folds one character a cycle.
// Reset clears all valid flags and the scan state; a literal in flight is lost.
// ----------------------------------------------------------------------------
// integer_literal_parser: C-style integer literal parser
// Parses a decimal, octal, binary or hex literal with optional minus sign
// into a 64-bit two's complement value with an ok flag.
// ----------------------------------------------------------------------------
module integer_literal_parser
   import ilp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CharWidth-1:0]  req_tdata,   // [7:0] char_code
   input  logic                  req_tuser,   // [0] char_present
   input  logic                  req_tlast,   // last_char
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ValueWidth-1:0] rsp_tdata,   // [63:0] parsed_value
   output logic                  rsp_tuser    // [0] parse_ok
);

   logic                  in_valid_ff, in_valid_in;
   logic [CharWidth-1:0]  char_ff;
   logic                  present_ff;
   logic                  last_ff;

   logic                  fin_valid_ff, fin_valid_in;
   result_type            fin_ff;
   result_type            scan_result;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff;
   logic [ValueWidth-1:0] rsp_value_ff;

   logic                  out_move;
   logic                  fin_free;
   logic                  take;
   logic                  req_take;

   assign out_move   = !rsp_valid_ff || rsp_tready;
   assign fin_free   = !fin_valid_ff || out_move;
   // A character that closes no literal needs no room downstream
   assign take       = in_valid_ff && (!last_ff || fin_free);
   assign req_tready = !in_valid_ff || take;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !take);
   assign fin_valid_in = (take && last_ff) || (fin_valid_ff && !out_move);
   assign rsp_valid_in = out_move ? fin_valid_ff : rsp_valid_ff;

   ilp_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .char_code    (char_ff),
      .char_present (present_ff),
      .last_char    (last_ff),
      .result       (scan_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff    <= req_tdata;
         present_ff <= req_tuser;
         last_ff    <= req_tlast;
      end
      if (take && last_ff) begin
         fin_ff <= scan_result;
      end
      if (out_move && fin_valid_ff) begin
         rsp_ok_ff <= fin_ff.ok;
         if (!fin_ff.ok) begin
            rsp_value_ff <= '0;
         end else if (fin_ff.negative) begin
            rsp_value_ff <= ValueWidth'(0) - fin_ff.magnitude;
         end else begin
            rsp_value_ff <= fin_ff.magnitude;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_ok_ff;

endmodule

>>> design/ilp_checker.sv
// ----------------------------------------------------------------------------
// ilp_checker: port-level checks for the integer literal parser
// Watches the stream ports and flags ordering and result-format slips.
// ----------------------------------------------------------------------------
module ilp_checker
   import ilp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [CharWidth-1:0]  req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [ValueWidth-1:0] rsp_tdata,
   input  logic                  rsp_tuser
);

   // A stalled input item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser)
      && $stable(req_tlast))
      else $error("stalled input item changed");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A failed parse carries a zero value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("failed parse with nonzero value");

   // No result right out of reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // With the output side empty the input side never stalls
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
